// File: hdl/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and constants of the character LCD 4-bit write
// sequencer: request codes, register indexes, job descriptor, init program.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_DATA    = 2'd1,
    OP_CURSOR  = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENABLE_HIGH_MS  = 3'd0,
    CFG_ENABLE_LOW_MS   = 3'd1,
    CFG_POWER_UP_MS     = 3'd2,
    CFG_FUNCTION_SET    = 3'd3,
    CFG_DISPLAY_CONTROL = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] RST_ENABLE_HIGH_MS  = 8'd2;
  localparam logic [7:0] RST_ENABLE_LOW_MS   = 8'd5;
  localparam logic [7:0] RST_POWER_UP_MS     = 8'd40;
  localparam logic [7:0] RST_FUNCTION_SET    = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0C;

  localparam logic [7:0] CMD_INIT_A = 8'h33;
  localparam logic [7:0] CMD_INIT_B = 8'h32;
  localparam logic [7:0] CMD_HOME   = 8'h02;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] DDRAM_BASE = 8'h80;
  localparam logic [4:0] MAX_COLUMN = 5'd19;

  localparam logic [7:0] WAIT_SHORT_MS = 8'd1;
  localparam logic [7:0] WAIT_LONG_MS  = 8'd2;

  // Step numbers of the init program
  localparam logic [4:0] STEP_POWER_UP  = 5'd0;
  localparam logic [4:0] STEP_INIT_A    = 5'd1;
  localparam logic [4:0] STEP_INIT_B    = 5'd5;
  localparam logic [4:0] STEP_FUNC      = 5'd9;
  localparam logic [4:0] STEP_FUNC_WAIT = 5'd13;
  localparam logic [4:0] STEP_DISP      = 5'd14;
  localparam logic [4:0] STEP_DISP_WAIT = 5'd18;
  localparam logic [4:0] STEP_HOME      = 5'd19;
  localparam logic [4:0] STEP_HOME_WAIT = 5'd23;
  localparam logic [4:0] STEP_CLEAR     = 5'd24;
  localparam logic [4:0] INIT_LAST_STEP = 5'd27;
  localparam logic [4:0] BYTE_LAST_STEP = 5'd3;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  // Where the byte of a phase comes from
  typedef enum logic [2:0] {
    SRC_REQ   = 3'd0,
    SRC_ZERO  = 3'd1,
    SRC_INITA = 3'd2,
    SRC_INITB = 3'd3,
    SRC_FUNC  = 3'd4,
    SRC_DISP  = 3'd5,
    SRC_HOME  = 3'd6,
    SRC_CLEAR = 3'd7
  } src_e;

  // Hold-time override for wait phases
  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_PU    = 2'd1,
    WAIT_SHORT = 2'd2,
    WAIT_LONG  = 2'd3
  } wait_e;

  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  typedef struct packed {
    logic [7:0] enable_high_ms;
    logic [7:0] enable_low_ms;
    logic [7:0] power_up_ms;
    logic [7:0] function_set;
    logic [7:0] display_control;
  } cfg_t;

  typedef struct packed {
    src_e       src;
    logic [1:0] phase;
    wait_e      wait_kind;
  } step_desc_t;

  typedef struct packed {
    logic busy;
    logic loading;
  } bk_status_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    unique case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

  // Decode one step of the init program
  function automatic step_desc_t init_step(input logic [4:0] step);
    step_desc_t d;
    d.src       = SRC_ZERO;
    d.phase     = 2'd0;
    d.wait_kind = WAIT_NONE;
    priority if (step == STEP_POWER_UP) begin
      d.src       = SRC_ZERO;
      d.wait_kind = WAIT_PU;
    end else if (step < STEP_INIT_B) begin
      d.src   = SRC_INITA;
      d.phase = 2'(step - STEP_INIT_A);
    end else if (step < STEP_FUNC) begin
      d.src   = SRC_INITB;
      d.phase = 2'(step - STEP_INIT_B);
    end else if (step < STEP_FUNC_WAIT) begin
      d.src   = SRC_FUNC;
      d.phase = 2'(step - STEP_FUNC);
    end else if (step == STEP_FUNC_WAIT) begin
      d.src       = SRC_FUNC;
      d.wait_kind = WAIT_SHORT;
    end else if (step < STEP_DISP_WAIT) begin
      d.src   = SRC_DISP;
      d.phase = 2'(step - STEP_DISP);
    end else if (step == STEP_DISP_WAIT) begin
      d.src       = SRC_DISP;
      d.wait_kind = WAIT_LONG;
    end else if (step < STEP_HOME_WAIT) begin
      d.src   = SRC_HOME;
      d.phase = 2'(step - STEP_HOME);
    end else if (step == STEP_HOME_WAIT) begin
      d.src       = SRC_HOME;
      d.wait_kind = WAIT_SHORT;
    end else begin
      d.src   = SRC_CLEAR;
      d.phase = 2'(step - STEP_CLEAR);
    end
    return d;
  endfunction

endpackage

// File: hdl/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// Request decoder: classifies a request and turns a cursor move into the
// DDRAM address command, then hands a job to the queue.
// ----------------------------------------------------------------------------
module clcd_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_operation_i,
  input  logic [7:0]        in_byte_value_i,
  input  logic [1:0]        in_row_i,
  input  logic [4:0]        in_column_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output clcd_pkg::job_t    job_o
);
  import clcd_pkg::*;

  op_e        op;
  logic [4:0] col_clamped;
  logic [7:0] cursor_addr;

  assign op          = op_e'(in_operation_i);
  // clamp the column to the last visible one
  assign col_clamped = (in_column_i > MAX_COLUMN) ? MAX_COLUMN : in_column_i;
  assign cursor_addr = DDRAM_BASE + row_offset(in_row_i) + {3'b000, col_clamped};

  always_comb begin
    job_o.is_init  = 1'b0;
    job_o.rs       = 1'b0;
    job_o.byte_val = in_byte_value_i;
    unique case (op)
      OP_COMMAND: job_o.rs = 1'b0;
      OP_DATA:    job_o.rs = 1'b1;
      OP_CURSOR:  job_o.byte_val = cursor_addr;
      OP_INIT:    job_o.is_init = 1'b1;
      default:    job_o.is_init = 1'b0;
    endcase
  end

  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

endmodule

// File: hdl/clcd_queue.sv
// ----------------------------------------------------------------------------
// clcd_queue
// Two-entry job queue between the request decoder and the phase sequencer.
// ----------------------------------------------------------------------------
module clcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  clcd_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output clcd_pkg::job_t pop_job_o
);
  import clcd_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: hdl/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back
// Phase sequencer: steps through the bus phases of one job and presents
// each phase in an output register.
// ----------------------------------------------------------------------------
module clcd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clcd_pkg::cfg_t       cfg_i,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  clcd_pkg::job_t       job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_register_select_o,
  output logic [3:0]           out_data_nibble_o,
  output logic                 out_enable_level_o,
  output logic [7:0]           out_hold_ms_o,
  output logic                 out_last_phase_o,
  output clcd_pkg::bk_status_t status_o
);
  import clcd_pkg::*;

  logic       busy_q, busy_d;
  job_t       job_q;
  logic [4:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       rs_q;
  logic [3:0] nib_q;
  logic       en_q;
  logic [7:0] hold_q;
  logic       last_q;

  logic       load, emit;
  step_desc_t desc;
  logic [7:0] cur_byte;
  logic       ph_rs, ph_en, ph_last;
  logic [3:0] ph_nib;
  logic [7:0] ph_hold;

  assign load        = !busy_q && job_valid_i;
  assign job_ready_o = !busy_q;
  assign emit        = busy_q && (!out_valid_q || out_ready_i);

  // decode the current step into pin levels
  always_comb begin
    if (job_q.is_init) begin
      desc = init_step(step_q);
    end else begin
      desc.src       = SRC_REQ;
      desc.phase     = step_q[1:0];
      desc.wait_kind = WAIT_NONE;
    end

    unique case (desc.src)
      SRC_REQ:   cur_byte = job_q.byte_val;
      SRC_ZERO:  cur_byte = 8'h00;
      SRC_INITA: cur_byte = CMD_INIT_A;
      SRC_INITB: cur_byte = CMD_INIT_B;
      SRC_FUNC:  cur_byte = cfg_i.function_set;
      SRC_DISP:  cur_byte = cfg_i.display_control;
      SRC_HOME:  cur_byte = CMD_HOME;
      SRC_CLEAR: cur_byte = CMD_CLEAR;
      default:   cur_byte = 8'h00;
    endcase

    ph_rs = job_q.is_init ? 1'b0 : job_q.rs;
    // waits keep the pins of the low nibble just sent (zero for the power-up wait), enable low
    if (desc.wait_kind != WAIT_NONE || desc.phase[1]) begin
      ph_nib = cur_byte[3:0];
    end else begin
      ph_nib = cur_byte[7:4];
    end
    ph_en = (desc.wait_kind == WAIT_NONE) && !desc.phase[0];

    unique case (desc.wait_kind)
      WAIT_PU:    ph_hold = cfg_i.power_up_ms;
      WAIT_SHORT: ph_hold = WAIT_SHORT_MS;
      WAIT_LONG:  ph_hold = WAIT_LONG_MS;
      default:    ph_hold = ph_en ? cfg_i.enable_high_ms : cfg_i.enable_low_ms;
    endcase

    ph_last = job_q.is_init ? (step_q == INIT_LAST_STEP) : (step_q == BYTE_LAST_STEP);
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      busy_d = 1'b1;
      step_d = '0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      if (ph_last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (emit) begin
      rs_q   <= ph_rs;
      nib_q  <= ph_nib;
      en_q   <= ph_en;
      hold_q <= ph_hold;
      last_q <= ph_last;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_register_select_o = rs_q;
  assign out_data_nibble_o     = nib_q;
  assign out_enable_level_o    = en_q;
  assign out_hold_ms_o         = hold_q;
  assign out_last_phase_o      = last_q;

  assign status_o.busy    = busy_q;
  assign status_o.loading = load;

endmodule

// File: hdl/char_lcd_4bit_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Host side of a 4-bit character LCD write: turns command, data, cursor and
// initialize requests into timed bus phases.
// ----------------------------------------------------------------------------
// Each request produces a run of phases (register select, data nibble, enable
// level, hold time in ms, last-phase mark): four for a command, data byte or
// cursor move, twenty-eight for initialization. The block does not time the
// holds itself; the consumer applies hold_ms. A request waits in a two-entry
// queue, is registered into the phase sequencer once it is free, then yields
// one phase per cycle while the output side is ready; a job is loaded only
// after the previous one has emitted its last phase. Registers are to be
// written through the cfg port only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_operation_i,
  input  logic [7:0] in_byte_value_i,
  input  logic [1:0] in_row_i,
  input  logic [4:0] in_column_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_register_select_o,
  output logic [3:0] out_data_nibble_o,
  output logic       out_enable_level_o,
  output logic [7:0] out_hold_ms_o,
  output logic       out_last_phase_o
);
  import clcd_pkg::*;

  cfg_t       cfg_q;
  job_t       front_job, queue_job;
  logic       front_valid, front_ready;
  logic       queue_valid, queue_ready;
  bk_status_t bk_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_high_ms  <= RST_ENABLE_HIGH_MS;
      cfg_q.enable_low_ms   <= RST_ENABLE_LOW_MS;
      cfg_q.power_up_ms     <= RST_POWER_UP_MS;
      cfg_q.function_set    <= RST_FUNCTION_SET;
      cfg_q.display_control <= RST_DISPLAY_CONTROL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE_HIGH_MS:  cfg_q.enable_high_ms  <= cfg_wdata_i;
        CFG_ENABLE_LOW_MS:   cfg_q.enable_low_ms   <= cfg_wdata_i;
        CFG_POWER_UP_MS:     cfg_q.power_up_ms     <= cfg_wdata_i;
        CFG_FUNCTION_SET:    cfg_q.function_set    <= cfg_wdata_i;
        CFG_DISPLAY_CONTROL: cfg_q.display_control <= cfg_wdata_i;
        default:             cfg_q                 <= cfg_q;
      endcase
    end
  end

  clcd_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_operation_i  (in_operation_i),
    .in_byte_value_i (in_byte_value_i),
    .in_row_i        (in_row_i),
    .in_column_i     (in_column_i),
    .job_valid_o     (front_valid),
    .job_ready_i     (front_ready),
    .job_o           (front_job)
  );

  clcd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_job_i   (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_job_o    (queue_job)
  );

  clcd_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .job_valid_i           (queue_valid),
    .job_ready_o           (queue_ready),
    .job_i                 (queue_job),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_register_select_o (out_register_select_o),
    .out_data_nibble_o     (out_data_nibble_o),
    .out_enable_level_o    (out_enable_level_o),
    .out_hold_ms_o         (out_hold_ms_o),
    .out_last_phase_o      (out_last_phase_o),
    .status_o              (bk_status)
  );

`ifndef SYNTHESIS
  // queue can never be full and empty at once
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_ready || queue_valid)
    else $error("job queue both full and empty");

  // sequencer drops busy only after registering the final phase
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bk_status.busy) |-> out_valid_o && out_last_phase_o)
    else $error("sequencer finished without a final phase");

  // every request ends with enable low
  a_last_enable_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_phase_o |-> !out_enable_level_o)
    else $error("final phase left enable high");

  // a new job is loaded only while the sequencer is free
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.loading |-> !bk_status.busy)
    else $error("job loaded while sequencer busy");
`endif

endmodule

// File: verif/char_lcd_4bit_write_sequencer_tb.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_tb
// Self-checking bench for the 4-bit character LCD write sequencer. A directed
// table of requests, then random requests under several register settings.
// Every accepted request is expanded into its bus phases by a local model and
// each phase leaving the block is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clcd_pkg::*;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       en;
    logic [7:0] hold;
    logic       last;
  } bus_phase_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
    logic [1:0] row;
    logic [4:0] column;
  } request_t;

  typedef struct packed {
    request_t   req;
    logic       typed;
    bus_phase_t first;
  } directed_row_t;

  localparam logic RsCommand = 1'b0;
  localparam logic RsData    = 1'b1;
  localparam logic EnHigh    = 1'b1;
  localparam logic EnLow     = 1'b0;

  localparam logic [7:0] RowBase [4] = '{8'h00, 8'h40, 8'h14, 8'h54};
  localparam logic [2:0] FirstUnusedIdx = 3'(CFG_DISPLAY_CONTROL) + 3'd1;

  localparam int NumDirected   = 16;
  localparam int NumPhases     = 5;
  localparam int ItemsPerPhase = 20;
  localparam int MaxGap        = 7;
  localparam int LongStall     = 300;
  localparam int SettleCycles  = 8;
  localparam int CycleLimit    = 400000;

  // Typed first phases assume the reset register values.
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{'{OP_COMMAND, 8'h00, 2'd0, 5'd0 }, 1'b1, '{RsCommand, 4'h0, EnHigh, 8'd2, 1'b0}},
    '{'{OP_COMMAND, 8'hFF, 2'd0, 5'd0 }, 1'b1, '{RsCommand, 4'hF, EnHigh, 8'd2, 1'b0}},
    '{'{OP_DATA,    8'h00, 2'd0, 5'd0 }, 1'b1, '{RsData,    4'h0, EnHigh, 8'd2, 1'b0}},
    '{'{OP_DATA,    8'hFF, 2'd3, 5'd31}, 1'b1, '{RsData,    4'hF, EnHigh, 8'd2, 1'b0}},
    '{'{OP_DATA,    8'hA5, 2'd1, 5'd7 }, 1'b0, '0},
    '{'{OP_COMMAND, 8'h5A, 2'd3, 5'd31}, 1'b0, '0},
    '{'{OP_CURSOR,  8'hFF, 2'd0, 5'd0 }, 1'b1, '{RsCommand, 4'h8, EnHigh, 8'd2, 1'b0}},
    '{'{OP_CURSOR,  8'h00, 2'd1, 5'd19}, 1'b1, '{RsCommand, 4'hD, EnHigh, 8'd2, 1'b0}},
    '{'{OP_CURSOR,  8'h00, 2'd2, 5'd20}, 1'b1, '{RsCommand, 4'hA, EnHigh, 8'd2, 1'b0}},
    '{'{OP_CURSOR,  8'h3C, 2'd3, 5'd31}, 1'b1, '{RsCommand, 4'hE, EnHigh, 8'd2, 1'b0}},
    '{'{OP_CURSOR,  8'hFF, 2'd3, 5'd0 }, 1'b0, '0},
    '{'{OP_CURSOR,  8'h00, 2'd2, 5'd5 }, 1'b0, '0},
    '{'{OP_INIT,    8'hFF, 2'd3, 5'd31}, 1'b1, '{RsCommand, 4'h0, EnLow,  8'd40, 1'b0}},
    '{'{OP_INIT,    8'h00, 2'd0, 5'd0 }, 1'b0, '0},
    '{'{OP_DATA,    8'h3C, 2'd0, 5'd0 }, 1'b0, '0},
    '{'{OP_CURSOR,  8'h81, 2'd1, 5'd20}, 1'b0, '0}
  };

  localparam cfg_t FixedSettings [3] = '{
    '{8'd1,   8'd1,   8'd1,   8'h00, 8'h00},
    '{8'd255, 8'd255, 8'd255, 8'hFF, 8'hFF},
    '{8'd0,   8'd0,   8'd0,   8'h5A, 8'hA5}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] in_operation_i = '0;
  logic [7:0] in_byte_value_i = '0;
  logic [1:0] in_row_i = '0;
  logic [4:0] in_column_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       out_register_select_o;
  logic [3:0] out_data_nibble_o;
  logic       out_enable_level_o;
  logic [7:0] out_hold_ms_o;
  logic       out_last_phase_o;

  cfg_t       lcd_cfg;
  bus_phase_t expected_phases [$];
  int         mismatches = 0;
  bit         sender_idles = 1'b1;
  bit         sink_idles = 1'b1;
  bit         long_stall_req = 1'b0;

  char_lcd_4bit_write_sequencer uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .in_operation_i        (in_operation_i),
    .in_byte_value_i       (in_byte_value_i),
    .in_row_i              (in_row_i),
    .in_column_i           (in_column_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_register_select_o (out_register_select_o),
    .out_data_nibble_o     (out_data_nibble_o),
    .out_enable_level_o    (out_enable_level_o),
    .out_hold_ms_o         (out_hold_ms_o),
    .out_last_phase_o      (out_last_phase_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void push_phase(input logic rs, input logic [3:0] nibble,
                                     input logic en, input logic [7:0] hold);
    expected_phases.push_back('{rs, nibble, en, hold, 1'b0});
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] value);
    push_phase(rs, value[7:4], EnHigh, lcd_cfg.enable_high_ms);
    push_phase(rs, value[7:4], EnLow, lcd_cfg.enable_low_ms);
    push_phase(rs, value[3:0], EnHigh, lcd_cfg.enable_high_ms);
    push_phase(rs, value[3:0], EnLow, lcd_cfg.enable_low_ms);
  endfunction

  function automatic void predict_bus_phases(input request_t req);
    logic [4:0] col;
    bus_phase_t tail;
    case (req.op)
      OP_COMMAND: push_byte(RsCommand, req.value);
      OP_DATA:    push_byte(RsData, req.value);
      OP_CURSOR: begin
        col = (req.column > MAX_COLUMN) ? MAX_COLUMN : req.column;
        push_byte(RsCommand, DDRAM_BASE + RowBase[req.row] + 8'(col));
      end
      OP_INIT: begin
        // power-up wait drives all pins low
        push_phase(RsCommand, 4'h0, EnLow, lcd_cfg.power_up_ms);
        push_byte(RsCommand, CMD_INIT_A);
        push_byte(RsCommand, CMD_INIT_B);
        push_byte(RsCommand, lcd_cfg.function_set);
        push_phase(RsCommand, lcd_cfg.function_set[3:0], EnLow, WAIT_SHORT_MS);
        push_byte(RsCommand, lcd_cfg.display_control);
        push_phase(RsCommand, lcd_cfg.display_control[3:0], EnLow, WAIT_LONG_MS);
        push_byte(RsCommand, CMD_HOME);
        push_phase(RsCommand, CMD_HOME[3:0], EnLow, WAIT_SHORT_MS);
        push_byte(RsCommand, CMD_CLEAR);
      end
      default: ;
    endcase
    tail = expected_phases.pop_back();
    tail.last = 1'b1;
    expected_phases.push_back(tail);
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_phase();
    bus_phase_t want;
    if (expected_phases.size() == 0) begin
      $display("%0t: unexpected phase: expected none, actual rs=%0b nib=%0h en=%0b hold=%0d",
               $time, out_register_select_o, out_data_nibble_o, out_enable_level_o,
               out_hold_ms_o);
      mismatches++;
      return;
    end
    want = expected_phases.pop_front();
    compare_field("register_select", 8'(want.rs), 8'(out_register_select_o));
    compare_field("data_nibble", 8'(want.nibble), 8'(out_data_nibble_o));
    compare_field("enable_level", 8'(want.en), 8'(out_enable_level_o));
    compare_field("hold_ms", want.hold, out_hold_ms_o);
    compare_field("last_phase", 8'(want.last), 8'(out_last_phase_o));
  endfunction

  task automatic write_register(input logic [2:0] index, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (index)
      CFG_ENABLE_HIGH_MS:  lcd_cfg.enable_high_ms = value;
      CFG_ENABLE_LOW_MS:   lcd_cfg.enable_low_ms = value;
      CFG_POWER_UP_MS:     lcd_cfg.power_up_ms = value;
      CFG_FUNCTION_SET:    lcd_cfg.function_set = value;
      CFG_DISPLAY_CONTROL: lcd_cfg.display_control = value;
      default: ;  // unused index: no effect
    endcase
  endtask

  task automatic offer_request(input request_t req, input logic typed,
                               input bus_phase_t first);
    int gap;
    int head;
    gap = sender_idles ? $urandom_range(MaxGap, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_operation_i  <= req.op;
    in_byte_value_i <= req.value;
    in_row_i        <= req.row;
    in_column_i     <= req.column;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    head = expected_phases.size();
    predict_bus_phases(req);
    if (typed) expected_phases[head] = first;
  endtask

  // drop valid so the last transaction is not offered again while draining
  task automatic drain_phases();
    in_valid_i <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result sink: per-phase random back-pressure, one long hold-off on request.
  initial begin : phase_sink
    int gap;
    wait (rst_ni);
    forever begin
      gap = sink_idles ? $urandom_range(MaxGap, 0) : 0;
      if (long_stall_req) begin
        gap = LongStall;
        long_stall_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      check_phase();
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    request_t req;
    cfg_t     setting;
    lcd_cfg = '{RST_ENABLE_HIGH_MS, RST_ENABLE_LOW_MS, RST_POWER_UP_MS,
                RST_FUNCTION_SET, RST_DISPLAY_CONTROL};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      offer_request(DirectedRows[i].req, DirectedRows[i].typed, DirectedRows[i].first);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_phases();
      if (ph < 3) begin
        setting = FixedSettings[ph];
      end else begin
        setting = '{8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    8'($urandom_range(255, 0))};
      end
      write_register(CFG_ENABLE_HIGH_MS, setting.enable_high_ms);
      write_register(CFG_ENABLE_LOW_MS, setting.enable_low_ms);
      write_register(CFG_POWER_UP_MS, setting.power_up_ms);
      write_register(CFG_FUNCTION_SET, setting.function_set);
      write_register(CFG_DISPLAY_CONTROL, setting.display_control);
      write_register(3'($urandom_range(7, FirstUnusedIdx)), 8'($urandom_range(255, 0)));
      cfg_we_i <= 1'b0;

      // phase 1: sender never idles while the sink holds off; phase 2: neither idles
      sender_idles = (ph != 1) && (ph != 2);
      sink_idles   = (ph != 2);
      if (ph == 1) long_stall_req = 1'b1;

      for (int n = 0; n < ItemsPerPhase; n++) begin
        req.op     = op_e'($urandom_range(3, 0));
        req.value  = 8'($urandom_range(255, 0));
        req.row    = 2'($urandom_range(3, 0));
        req.column = 5'($urandom_range(31, 0));
        offer_request(req, 1'b0, '0);
      end
    end
    drain_phases();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
